>>> src/bed_pkg.sv
// ----------------------------------------------------------------------------
// bed_pkg
// Widths, reset values, register indexes and fixed constants shared by the
// bass envelope detector modules.
// ----------------------------------------------------------------------------
`default_nettype none

package bed_pkg;

    localparam int MAX_BLOCK  = 1024;

    localparam int SAMPLE_W   = 16;
    localparam int STATE_W    = 24;
    localparam int COEF_W     = 16;
    localparam int THR_W      = 16;
    localparam int GAIN_W     = 14;
    localparam int DISP_W     = 16;
    localparam int LVL_W      = 16;
    localparam int AMP_W      = 16;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // sample count holds MAX_BLOCK itself; each square is at most 2^30
    localparam int CNT_W      = $clog2(MAX_BLOCK + 1);
    localparam int SUM_W      = 31 + $clog2(MAX_BLOCK);
    localparam int DIVD_W     = SUM_W + 2;
    localparam int ROOT_W     = (DIVD_W + 1) / 2;
    localparam int SUB_W      = ROOT_W + 2;
    localparam int STEP_W     = $clog2(DIVD_W);

    localparam logic [STEP_W-1:0] DIV_LAST = STEP_W'(DIVD_W - 1);
    localparam logic [STEP_W-1:0] SQ_LAST  = STEP_W'(ROOT_W - 1);
    localparam logic [CNT_W-1:0]  CNT_MAX  = CNT_W'(MAX_BLOCK);

    // shared multiplier operand widths
    localparam int MUL_A_W = 26;
    localparam int MUL_B_W = 20;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // floor(v / 5) = (v * RECIP5) >> RECIP5_SHIFT for v below 2^19
    localparam logic [MUL_B_W-1:0] RECIP5       = 20'd419431;
    localparam int                 RECIP5_SHIFT = 21;

    localparam logic [COEF_W-1:0] COEF_RST = 16'd1262;
    localparam logic [THR_W-1:0]  THR_RST  = 16'd1311;
    localparam logic [GAIN_W-1:0] GAIN_RST = 14'd3072;
    localparam logic [DISP_W-1:0] DISP_RST = 16'd5120;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LOWPASS_COEF     = 2'd0,
        CFG_GATE_THRESHOLD   = 2'd1,
        CFG_LEVEL_GAIN       = 2'd2,
        CFG_MAX_DISPLACEMENT = 2'd3
    } cfg_idx_t;

endpackage

`default_nettype wire

>>> src/bed_divsqrt.sv
// ----------------------------------------------------------------------------
// bed_divsqrt
// Restoring divide of the scaled square sum by the sample count, followed by
// a digit-by-digit integer square root of the quotient, on one subtractor.
// ----------------------------------------------------------------------------
`default_nettype none

module bed_divsqrt
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [bed_pkg::DIVD_W-1:0] dividend,
    input  logic [bed_pkg::CNT_W-1:0]  divisor,
    output logic                       done,
    output logic [bed_pkg::ROOT_W-1:0] root
);
    import bed_pkg::*;

    typedef enum logic [2:0] {
        P_IDLE = 3'b001,
        P_DIV  = 3'b010,
        P_SQRT = 3'b100
    } phase_t;

    phase_t               phase_reg, phase_next;
    logic [STEP_W-1:0]    cnt_reg, cnt_next;
    logic [DIVD_W-1:0]    d_reg, d_next;
    logic [CNT_W-1:0]     dvs_reg, dvs_next;
    logic [CNT_W-1:0]     rem_reg, rem_next;
    logic [2*ROOT_W-1:0]  v_reg, v_next;
    logic [ROOT_W:0]      srem_reg, srem_next;
    logic [ROOT_W-1:0]    root_reg, root_next;
    logic                 done_reg, done_next;

    logic [CNT_W:0]       div_shift;
    logic [SUB_W-1:0]     sq_shift;
    logic [SUB_W-1:0]     sq_trial;
    logic [SUB_W-1:0]     sub_a;
    logic [SUB_W-1:0]     sub_b;
    logic [SUB_W:0]       sub_d;
    logic                 fits;
    logic [DIVD_W-1:0]    quot;

    assign div_shift = {rem_reg, d_reg[DIVD_W-1]};
    assign sq_shift  = {srem_reg[ROOT_W-1:0], v_reg[2*ROOT_W-1 -: 2]};
    assign sq_trial  = {root_reg, 2'b01};

    always_comb
    begin
        if (phase_reg == P_SQRT)
        begin
            sub_a = sq_shift;
            sub_b = sq_trial;
        end
        else
        begin
            sub_a = SUB_W'(div_shift);
            sub_b = SUB_W'(dvs_reg);
        end
    end

    assign sub_d = {1'b0, sub_a} - {1'b0, sub_b};
    assign fits  = ~sub_d[SUB_W];
    assign quot  = {d_reg[DIVD_W-2:0], fits};

    always_comb
    begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        d_next     = d_reg;
        dvs_next   = dvs_reg;
        rem_next   = rem_reg;
        v_next     = v_reg;
        srem_next  = srem_reg;
        root_next  = root_reg;
        done_next  = 1'b0;
        unique case (phase_reg)
            P_IDLE:
            begin
                if (start)
                begin
                    d_next     = dividend;
                    dvs_next   = divisor;
                    rem_next   = '0;
                    cnt_next   = '0;
                    phase_next = P_DIV;
                end
            end
            P_DIV:
            begin
                rem_next = fits ? sub_d[CNT_W-1:0] : div_shift[CNT_W-1:0];
                d_next   = quot;
                if (cnt_reg == DIV_LAST)
                begin
                    v_next     = (2*ROOT_W)'(quot);
                    srem_next  = '0;
                    root_next  = '0;
                    cnt_next   = '0;
                    phase_next = P_SQRT;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            P_SQRT:
            begin
                srem_next = fits ? sub_d[ROOT_W:0] : sq_shift[ROOT_W:0];
                root_next = {root_reg[ROOT_W-2:0], fits};
                v_next    = {v_reg[2*ROOT_W-3:0], 2'b00};
                if (cnt_reg == SQ_LAST)
                begin
                    done_next  = 1'b1;
                    phase_next = P_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            default:
            begin
                phase_next = P_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= P_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        d_reg    <= d_next;
        dvs_reg  <= dvs_next;
        rem_reg  <= rem_next;
        v_reg    <= v_next;
        srem_reg <= srem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

`default_nettype wire

>>> src/bass_envelope_detector.sv
// ----------------------------------------------------------------------------
// bass_envelope_detector
// One-pole low-pass filter, block RMS, level smoothing and shake amplitude.
// ----------------------------------------------------------------------------
// Samples are taken one at a time while in_stall is low. An unmuted sample
// that does not end a block goes through a filter multiply, then square and
// accumulate, both on one shared multiplier; a muted one is taken without
// holding the input, or goes straight to the output state when it ends a
// block. After the last sample of an unmuted block, the mean is found
// by a bit-serial divide (43 steps) and its square root by a digit-serial
// root (22 steps) on one subtractor, then three more multiplies form the
// level and amplitude. The result is held in an output register; the next
// request is taken while it waits, and the block waits only when a new
// result is ready and the last one has not yet been taken. A muted last
// sample gives level 0, amplitude 0.
// ----------------------------------------------------------------------------
`default_nettype none

module bass_envelope_detector
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [bed_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bed_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic signed [bed_pkg::SAMPLE_W-1:0] sample,
    input  logic                           last,
    input  logic                           muted,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [bed_pkg::LVL_W-1:0]      level,
    output logic [bed_pkg::AMP_W-1:0]      amplitude
);
    import bed_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_FILT  = 9'b000000010,
        S_SQ    = 9'b000000100,
        S_DIV   = 9'b000001000,
        S_WAIT  = 9'b000010000,
        S_BLEND = 9'b000100000,
        S_GAIN  = 9'b001000000,
        S_SCALE = 9'b010000000,
        S_OUT   = 9'b100000000
    } state_t;

    state_t                     state_reg, state_next;
    logic [COEF_W-1:0]          coef_reg, coef_next;
    logic [THR_W-1:0]           thr_reg, thr_next;
    logic [GAIN_W-1:0]          gain_reg, gain_next;
    logic [DISP_W-1:0]          disp_reg, disp_next;
    logic signed [SAMPLE_W-1:0] smp_reg, smp_next;
    logic                       last_reg, last_next;
    logic signed [STATE_W-1:0]  fstate_reg, fstate_next;
    logic [SUM_W-1:0]           sum_reg, sum_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic [LVL_W-1:0]           lvl_reg, lvl_next;
    logic [24:0]                n_reg, n_next;
    logic [AMP_W-1:0]           amp_reg, amp_next;
    logic                       out_valid_reg, out_valid_next;
    logic [LVL_W-1:0]           out_lvl_reg, out_lvl_next;
    logic [AMP_W-1:0]           out_amp_reg, out_amp_next;

    logic                       accept;
    logic signed [MUL_A_W-1:0]  mul_a;
    logic signed [MUL_B_W-1:0]  mul_b;
    logic signed [MUL_P_W-1:0]  mul_p;
    logic signed [MUL_P_W-1:0]  rnd;
    logic signed [24:0]         diff;
    logic signed [26:0]         delta;
    logic signed [26:0]         fs_ext;
    logic signed [26:0]         nv;
    logic signed [15:0]         q;
    logic [15:0]                rms_sat;
    logic [18:0]                blend;
    logic [LVL_W-1:0]           gated;
    logic [39:0]                amp_sum;
    logic                       ds_start;
    logic                       ds_done;
    logic [ROOT_W-1:0]          ds_root;

    bed_divsqrt u_divsqrt
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ds_start),
        .dividend ({sum_reg, 2'b00}),
        .divisor  (cnt_reg),
        .done     (ds_done),
        .root     (ds_root)
    );

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;
    assign ds_start = (state_reg == S_DIV);

    assign diff    = {smp_reg[SAMPLE_W-1], smp_reg, 8'b0} - {fstate_reg[STATE_W-1], fstate_reg};
    assign q       = fstate_reg[STATE_W-1:8];
    assign rms_sat = (ds_root > ROOT_W'(16'hFFFF)) ? 16'hFFFF : ds_root[15:0];
    assign blend   = {3'b000, lvl_reg} + {2'b00, lvl_reg, 1'b0} + {2'b00, rms_sat, 1'b0}
                   + 19'd2;
    assign gated   = (lvl_reg < thr_reg) ? '0 : lvl_reg;

    always_comb
    begin
        unique case (state_reg)
            S_FILT:
            begin
                mul_a = {diff[24], diff};
                mul_b = {4'b0000, coef_reg};
            end
            S_SQ:
            begin
                mul_a = {{10{q[15]}}, q};
                mul_b = {{4{q[15]}}, q};
            end
            S_BLEND:
            begin
                mul_a = {7'b0, blend};
                mul_b = RECIP5;
            end
            S_GAIN:
            begin
                mul_a = {10'b0, gated};
                mul_b = {6'b0, gain_reg};
            end
            S_SCALE:
            begin
                mul_a = {1'b0, n_reg};
                mul_b = {4'b0000, disp_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p   = mul_a * mul_b;
    assign rnd     = mul_p + MUL_P_W'(32768);
    assign delta   = rnd[42:16];
    assign fs_ext  = {{3{fstate_reg[STATE_W-1]}}, fstate_reg};
    assign nv      = fs_ext + delta;
    assign amp_sum = mul_p[39:0] + 40'd8388608;

    always_comb
    begin
        state_next     = state_reg;
        coef_next      = coef_reg;
        thr_next       = thr_reg;
        gain_next      = gain_reg;
        disp_next      = disp_reg;
        smp_next       = smp_reg;
        last_next      = last_reg;
        fstate_next    = fstate_reg;
        sum_next       = sum_reg;
        cnt_next       = cnt_reg;
        lvl_next       = lvl_reg;
        n_next         = n_reg;
        amp_next       = amp_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_lvl_next   = out_lvl_reg;
        out_amp_next   = out_amp_reg;

        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_LOWPASS_COEF:     coef_next = cfg_data[COEF_W-1:0];
                CFG_GATE_THRESHOLD:   thr_next  = cfg_data[THR_W-1:0];
                CFG_LEVEL_GAIN:       gain_next = cfg_data[GAIN_W-1:0];
                CFG_MAX_DISPLACEMENT: disp_next = cfg_data[DISP_W-1:0];
                default:              ;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    smp_next  = sample;
                    last_next = last;
                    if (!muted)
                    begin
                        state_next = S_FILT;
                    end
                    else if (last)
                    begin
                        lvl_next   = '0;
                        amp_next   = '0;
                        sum_next   = '0;
                        cnt_next   = '0;
                        state_next = S_OUT;
                    end
                end
            end
            S_FILT:
            begin
                if (nv > 27'sd8388607)
                begin
                    fstate_next = 24'sh7FFFFF;
                end
                else if (nv < -27'sd8388608)
                begin
                    fstate_next = 24'sh800000;
                end
                else
                begin
                    fstate_next = nv[STATE_W-1:0];
                end
                state_next = S_SQ;
            end
            S_SQ:
            begin
                if (cnt_reg < CNT_MAX)
                begin
                    sum_next = sum_reg + SUM_W'(mul_p[30:0]);
                    cnt_next = cnt_reg + 1'b1;
                end
                state_next = last_reg ? S_DIV : S_IDLE;
            end
            S_DIV:
            begin
                sum_next   = '0;
                cnt_next   = '0;
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (ds_done)
                begin
                    state_next = S_BLEND;
                end
            end
            S_BLEND:
            begin
                lvl_next   = mul_p[RECIP5_SHIFT +: LVL_W];
                state_next = S_GAIN;
            end
            S_GAIN:
            begin
                n_next     = (mul_p[29:0] > 30'd16777216) ? 25'd16777216 : mul_p[24:0];
                state_next = S_SCALE;
            end
            S_SCALE:
            begin
                amp_next   = amp_sum[39:24];
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_lvl_next   = lvl_reg;
                    out_amp_next   = amp_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            coef_reg      <= COEF_RST;
            thr_reg       <= THR_RST;
            gain_reg      <= GAIN_RST;
            disp_reg      <= DISP_RST;
            fstate_reg    <= '0;
            sum_reg       <= '0;
            cnt_reg       <= '0;
            lvl_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            coef_reg      <= coef_next;
            thr_reg       <= thr_next;
            gain_reg      <= gain_next;
            disp_reg      <= disp_next;
            fstate_reg    <= fstate_next;
            sum_reg       <= sum_next;
            cnt_reg       <= cnt_next;
            lvl_reg       <= lvl_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        smp_reg     <= smp_next;
        last_reg    <= last_next;
        n_reg       <= n_next;
        amp_reg     <= amp_next;
        out_lvl_reg <= out_lvl_next;
        out_amp_reg <= out_amp_next;
    end

    assign out_valid = out_valid_reg;
    assign level     = out_lvl_reg;
    assign amplitude = out_amp_reg;

endmodule

`default_nettype wire

>>> src/bed_checker.sv
// ----------------------------------------------------------------------------
// bed_checker
// Port-level checks of the bass envelope detector, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bed_checker
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [bed_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bed_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           in_valid,
    input  logic                           in_stall,
    input  logic                           last,
    input  logic                           muted,
    input  logic                           out_valid,
    input  logic                           out_stall,
    input  logic [bed_pkg::LVL_W-1:0]      level,
    input  logic [bed_pkg::AMP_W-1:0]      amplitude
);

    logic in_take;

    assign in_take = in_valid && !in_stall;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(level) && $stable(amplitude))
        else $error("stalled result changed or dropped");

    a_zero_level_amp: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (level != '0 || amplitude == '0))
        else $error("nonzero amplitude with zero level");

    a_muted_fast: assert property (@(posedge clk) disable iff (!rst_n)
        in_take && muted && !last |=> !in_stall)
        else $error("muted sample held the input");

    a_filter_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_take && !muted |=> in_stall)
        else $error("unmuted sample not processed");

    a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |-> !in_stall && !out_valid && !$isunknown({cfg_index, cfg_data}))
        else $error("register written while a request is in flight");

endmodule

bind bass_envelope_detector bed_checker u_bed_checker (.*);

`default_nettype wire

>>> test/tb_bass_envelope_detector.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bass_envelope_detector
// Self-checking bench for the bass envelope detector. A scoreboard mirrors
// the low-pass filter, block RMS, level smoothing and shake amplitude in
// fixed point. It records each accepted request and checks every result
// against the oldest predicted level and amplitude. Stimulus is a short
// directed block set, then random analysis blocks (plain, muted, partly
// muted, stray flags, steady tones) under several register settings.
// Random idle bursts are applied on both channels.
// ----------------------------------------------------------------------------
module tb_bass_envelope_detector;

    import bed_pkg::*;

    class envelope_scoreboard;
        logic [COEF_W-1:0]         coef;
        logic [THR_W-1:0]          thr;
        logic [GAIN_W-1:0]         gain;
        logic [DISP_W-1:0]         disp;
        logic signed [STATE_W-1:0] filt_state;
        logic [47:0]               sq_sum;
        int unsigned               n_samples;
        logic [LVL_W-1:0]          lvl;
        logic [LVL_W-1:0]          level_q[$];
        logic [AMP_W-1:0]          amp_q[$];
        int                        errors;

        function new();
            coef       = COEF_RST;
            thr        = THR_RST;
            gain       = GAIN_RST;
            disp       = DISP_RST;
            filt_state = '0;
            sq_sum     = '0;
            n_samples  = 0;
            lvl        = '0;
            errors     = 0;
        endfunction

        function int pending();
            return level_q.size();
        endfunction

        function void write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] d);
            case (idx)
                CFG_LOWPASS_COEF:     coef = d[COEF_W-1:0];
                CFG_GATE_THRESHOLD:   thr  = d[THR_W-1:0];
                CFG_LEVEL_GAIN:       gain = d[GAIN_W-1:0];
                CFG_MAX_DISPLACEMENT: disp = d[DISP_W-1:0];
                default:              ;
            endcase
        endfunction

        function void note_request(logic signed [SAMPLE_W-1:0] s, logic lst, logic mt);
            longint            diff;
            longint            prod;
            longint            nv;
            longint            q;
            longint unsigned   mean4;
            longint unsigned   root;
            longint unsigned   trial;
            longint unsigned   g;
            longint unsigned   n;
            longint unsigned   amp;
            if (mt)
            begin
                if (!lst)
                    return;
                lvl       = '0;
                sq_sum    = '0;
                n_samples = 0;
            end
            else
            begin
                diff = longint'(s) * 256 - longint'(filt_state);
                prod = diff * longint'(coef);
                nv   = longint'(filt_state) + ((prod + 32768) >>> 16);
                if (nv > 8388607)
                    nv = 8388607;
                if (nv < -8388608)
                    nv = -8388608;
                filt_state = nv[STATE_W-1:0];
                if (n_samples < MAX_BLOCK)
                begin
                    q = longint'(filt_state) >>> 8;
                    sq_sum = sq_sum + 48'(q * q);
                    n_samples++;
                end
                if (!lst)
                    return;
                if (n_samples != 0)
                begin
                    mean4 = (longint'(sq_sum) * 4) / n_samples;
                    root  = 0;
                    for (int b = 25; b >= 0; b--)
                    begin
                        trial = root | (64'd1 << b);
                        if (trial * trial <= mean4)
                            root = trial;
                    end
                    if (root > 65535)
                        root = 65535;
                    lvl = 16'((3 * longint'(lvl) + 2 * root + 2) / 5);
                end
                sq_sum    = '0;
                n_samples = 0;
            end
            g = (lvl < thr) ? 0 : lvl;
            n = g * gain;
            if (n > (64'd1 << 24))
                n = 64'd1 << 24;
            amp = (n * disp + (64'd1 << 23)) >> 24;
            level_q.push_back(lvl);
            amp_q.push_back(amp[AMP_W-1:0]);
        endfunction

        task report(string msg);
            $display("%0t ns: %s", $time, msg);
            errors++;
        endtask

        task check_result(logic [LVL_W-1:0] l, logic [AMP_W-1:0] a);
            logic [LVL_W-1:0] want_l;
            logic [AMP_W-1:0] want_a;
            if (level_q.size() == 0)
            begin
                report($sformatf("unexpected result level %0d amplitude %0d", l, a));
                return;
            end
            want_l = level_q.pop_front();
            want_a = amp_q.pop_front();
            if (l !== want_l)
                report($sformatf("level mismatch: got %0d, want %0d", l, want_l));
            if (a !== want_a)
                report($sformatf("amplitude mismatch: got %0d, want %0d", a, want_a));
        endtask
    endclass

    logic                        clk;
    logic                        rst_n;
    logic                        cfg_we;
    logic [CFG_IDX_W-1:0]        cfg_index;
    logic [CFG_DATA_W-1:0]       cfg_data;
    logic                        in_valid;
    logic                        in_stall;
    logic signed [SAMPLE_W-1:0]  sample;
    logic                        last;
    logic                        muted;
    logic                        out_valid;
    logic                        out_stall;
    logic [LVL_W-1:0]            level;
    logic [AMP_W-1:0]            amplitude;

    envelope_scoreboard sb;
    bit                 calm;

    bass_envelope_detector DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .sample    (sample),
        .last      (last),
        .muted     (muted),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .level     (level),
        .amplitude (amplitude)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("tb_bass_envelope_detector: errors");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_we)
                sb.write_reg(cfg_idx_t'(cfg_index), cfg_data);
            if (in_valid && !in_stall)
                sb.note_request(sample, last, muted);
            if (out_valid && !out_stall)
                sb.check_result(level, amplitude);
        end
    end

    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!calm && $urandom_range(0, 7) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(0, 12)) @(negedge clk);
            end
            else
                out_stall <= 1'b0;
        end
    end

    task push_sample(logic signed [SAMPLE_W-1:0] s, logic lst, logic mt);
        if (!calm && $urandom_range(0, 9) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge clk);
        end
        in_valid <= 1'b1;
        sample   <= s;
        last     <= lst;
        muted    <= mt;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task wait_results();
        in_valid <= 1'b0;
        @(negedge clk);
        while (sb.pending() != 0)
            @(negedge clk);
    endtask

    task settle();
        wait_results();
        repeat (120) @(negedge clk);
    endtask

    task program_regs(logic [15:0] coef, logic [15:0] thr, logic [15:0] gain,
                      logic [15:0] disp);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_LOWPASS_COEF;
        cfg_data  <= coef;
        @(negedge clk);
        cfg_index <= CFG_GATE_THRESHOLD;
        cfg_data  <= thr;
        @(negedge clk);
        cfg_index <= CFG_LEVEL_GAIN;
        cfg_data  <= gain;
        @(negedge clk);
        cfg_index <= CFG_MAX_DISPLACEMENT;
        cfg_data  <= disp;
        @(negedge clk);
        cfg_we    <= 1'b0;
        @(negedge clk);
    endtask

    function logic signed [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 3))
            0:       return 16'($urandom);
            1:       return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            2:       return 16'($urandom_range(0, 511)) - 16'sd256;
            default: return $urandom_range(0, 1) ? 16'($urandom_range(24000, 32767))
                                                 : -16'($urandom_range(24000, 32768));
        endcase
    endfunction

    task run_blocks(int budget);
        int                         sent;
        int                         kind;
        int                         len;
        logic                       mt;
        logic                       lst;
        logic signed [SAMPLE_W-1:0] tone;
        sent = 0;
        while (sent < budget)
        begin
            if ($urandom_range(0, 15) == 0)
                wait_results();
            kind = $urandom_range(0, 15);
            len  = (kind == 9) ? $urandom_range(13, 64) : $urandom_range(1, 12);
            tone = pick_sample();
            for (int i = 0; i < len; i++)
            begin
                lst = (i == len - 1);
                case (kind)
                    10, 11:  mt = 1'b1;
                    12, 13:  mt = $urandom_range(0, 1);
                    default: mt = 1'b0;
                endcase
                if (kind == 14)
                begin
                    lst = $urandom_range(0, 1);
                    mt  = $urandom_range(0, 1);
                end
                push_sample((kind == 15) ? tone : pick_sample(), lst, mt);
                if (!mt || lst)
                    sent++;
            end
        end
    endtask

    initial
    begin
        sb        = new();
        calm      = 1'b0;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = CFG_LOWPASS_COEF;
        cfg_data  = '0;
        in_valid  = 1'b0;
        sample    = '0;
        last      = 1'b0;
        muted     = 1'b0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        push_sample(16'sh7fff, 1'b0, 1'b0);
        push_sample(16'sh7fff, 1'b0, 1'b0);
        push_sample(16'sh7fff, 1'b1, 1'b0);
        push_sample(16'sh8000, 1'b1, 1'b0);
        push_sample(16'sh8000, 1'b0, 1'b0);
        push_sample(16'sh0000, 1'b1, 1'b0);
        push_sample(16'sh3039, 1'b0, 1'b1);
        push_sample(16'sh7fff, 1'b1, 1'b1);
        push_sample(16'sh8000, 1'b0, 1'b0);
        push_sample(16'sh7fff, 1'b0, 1'b1);
        push_sample(16'sh03e8, 1'b1, 1'b0);
        push_sample(16'sh7fff, 1'b0, 1'b0);
        push_sample(-16'sd1, 1'b1, 1'b1);
        push_sample(-16'sd1, 1'b1, 1'b0);
        push_sample(16'sh5555, 1'b0, 1'b0);
        push_sample(16'shaaaa, 1'b1, 1'b0);
        settle();

        program_regs(16'd65535, 16'd0, 16'd12800, 16'd38400);
        push_sample(16'sh7fff, 1'b1, 1'b0);
        push_sample(16'sh8000, 1'b1, 1'b0);
        push_sample(16'sh7fff, 1'b1, 1'b0);
        run_blocks(80);
        settle();

        program_regs(16'd0, 16'd32768, 16'd256, 16'd38400);
        run_blocks(80);
        settle();

        program_regs(16'd30000, 16'd0, 16'hffff, 16'd0);
        run_blocks(75);
        settle();

        program_regs(16'($urandom), 16'($urandom_range(0, 32768)),
                     16'($urandom_range(256, 12800)), 16'($urandom_range(0, 38400)));
        run_blocks(90);
        settle();

        program_regs(COEF_RST, THR_RST, 16'(GAIN_RST), DISP_RST);
        run_blocks(80);
        settle();

        program_regs(16'd50000, 16'd800, 16'd9000, 16'd25600);
        run_blocks(50);
        calm = 1'b1;
        run_blocks(70);
        settle();

        if (sb.errors == 0)
            $display("tb_bass_envelope_detector: clean");
        else
            $display("tb_bass_envelope_detector: errors");
        $finish;
    end

endmodule

>>> files.f
src/bed_pkg.sv
src/bed_divsqrt.sv
src/bass_envelope_detector.sv
src/bed_checker.sv
test/tb_bass_envelope_detector.sv
